/* design/ssk_pkg.sv */
// Package for the shared segment key table: result codes and cell types.
// No dependencies.
`default_nettype none
package ssk_pkg;
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_INVALID  = 3'd1,
    ERR_NOSPACE  = 3'd2,
    ERR_NOTFOUND = 3'd3,
    ERR_EXISTS   = 3'd4,
    ERR_REMOVED  = 3'd5
  } err_t;

  localparam logic [31:0] PRIVATE_KEY = 32'hFFFF_FFFF;
  localparam logic [31:0] OP_REMOVE   = 32'd0;

  // What passes along the chain of cells
  typedef struct packed {
    logic        found;    // a used slot with a matching key lies upstream
    logic        has_free; // a free slot lies upstream
    logic [30:0] size;     // stored size of the first match
    logic [6:0]  match_id; // id of first match
    logic [6:0]  free_id;  // id of first free slot
  } chain_t;

  // Request as it travels through the cells
  typedef struct packed {
    logic        mode;
    logic [31:0] key;
    logic [31:0] req_size;
    logic        create;
    logic        exclusive;
    logic [8:0]  perm_bits;
    logic [31:0] target_id;
    logic [31:0] ctl_op;
  } req_t;
endpackage
`default_nettype wire

/* design/ssk_cell.sv */
// One slot of the segment table: holds its entry and scans the request
// chain passing by. Depends on ssk_pkg.
`default_nettype none
module ssk_cell #(
  parameter logic [6:0] ID = 7'd1
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire ssk_pkg::chain_t     chain_in,
  output ssk_pkg::chain_t          chain_out,
  // write back, decided at the end of the chain
  input  wire                logic wr_alloc,
  input  wire                logic wr_clear,
  input  wire                logic [31:0] wr_key,
  input  wire                logic [30:0] wr_size,
  input  wire                logic [8:0]  wr_perm,
  output logic                     used
);
  logic        used_r, used_nxt;
  logic [31:0] key_r, key_nxt;
  logic [30:0] size_r, size_nxt;
  logic [8:0]  perm_r, perm_nxt;
  logic [31:0] probe_key;

  assign used = used_r;
  assign probe_key = wr_key;

  // chain step: first match and first free slot win
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && used_r && key_r == probe_key) begin
      chain_out.found    = 1'b1;
      chain_out.size     = size_r;
      chain_out.match_id = ID;
    end
    if (!chain_in.has_free && !used_r) begin
      chain_out.has_free = 1'b1;
      chain_out.free_id  = ID;
    end
  end

  // entry update
  always_comb begin
    used_nxt = used_r;
    key_nxt  = key_r;
    size_nxt = size_r;
    perm_nxt = perm_r;
    if (wr_alloc) begin
      used_nxt = 1'b1;
      key_nxt  = wr_key;
      size_nxt = wr_size;
      perm_nxt = wr_perm;
    end else if (wr_clear) begin
      used_nxt = 1'b0;
      key_nxt  = '0;
      size_nxt = '0;
      perm_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      key_r  <= '0;
      size_r <= '0;
      perm_r <= '0;
    end else begin
      used_r <= used_nxt;
      key_r  <= key_nxt;
      size_r <= size_nxt;
      perm_r <= perm_nxt;
    end
  end
endmodule
`default_nettype wire

/* design/shared_segment_key_table.sv */
// Top level of the shared segment key table: a row of slot cells scanned
// by a request chain. Depends on ssk_pkg and ssk_cell.
//
// Usage: drive in_* and raise start while busy is low; the request is
// taken at that edge. The row of SLOTS cells compares the key with every
// stored entry and finds the first free slot; the first-match and
// first-free marks ripple along the row of cells. The decision and the
// table update land at the next edge, and the result sits on out_* for the
// cycle after that edge with out_valid high. A new request is not taken
// while busy is high; busy rises at acceptance and stays high
// while the chain settles and the cells take the update, and is low again
// in the cycle the result is shown.
// The receiver cannot stall: each result is presented once only.
// Reset (rst_n low, synchronous) empties every slot and drops busy and
// out_valid.
`default_nettype none
module shared_segment_key_table #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_req_size,
  input  wire logic        in_create,
  input  wire logic        in_exclusive,
  input  wire logic [8:0]  in_perm_bits,
  input  wire logic [31:0] in_target_id,
  input  wire logic [31:0] in_ctl_op,
  output logic             out_valid,
  output logic             out_ok,
  output logic [6:0]       out_segment_id,
  output logic [2:0]       out_error_code
);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ssk_pkg::req_t   req_r;
  logic            pend_r, pend_nxt;
  logic            vld_r;
  logic            ok_r, ok_nxt;
  logic [6:0]      id_r, id_nxt;
  ssk_pkg::err_t   err_r, err_nxt;
  ssk_pkg::chain_t chain [SLOTS+1];
  logic [SLOTS-1:0] used, alloc_v, clear_v;
  logic            do_alloc, do_clear;
  logic            tid_ok;
  logic [6:0]      tid7;
  logic [IDX_W-1:0] tid_idx;

  assign chain[0] = '0;
  assign busy = pend_r;

  // row of cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ssk_cell #(.ID(7'(g + 1))) u_cell (
      .clk(clk), .rst_n(rst_n),
      .chain_in(chain[g]), .chain_out(chain[g+1]),
      .wr_alloc(alloc_v[g]), .wr_clear(clear_v[g]),
      .wr_key(req_r.key), .wr_size(req_r.req_size[30:0]),
      .wr_perm(req_r.perm_bits), .used(used[g])
    );
    assign alloc_v[g] = do_alloc && chain[SLOTS].free_id == 7'(g + 1);
    assign clear_v[g] = do_clear && tid7 == 7'(g + 1);
  end

  assign tid_ok = !req_r.target_id[31] && req_r.target_id != 32'd0 &&
                  req_r.target_id <= 32'(SLOTS);
  assign tid7 = req_r.target_id[6:0];
  // slot index of a valid id (id minus one, taken in IDX_W bits)
  assign tid_idx = req_r.target_id[IDX_W-1:0] - IDX_W'(1);

  // decision on the request held in the register
  always_comb begin
    ok_nxt   = 1'b0;
    id_nxt   = '0;
    err_nxt  = ssk_pkg::ERR_NONE;
    do_alloc = 1'b0;
    do_clear = 1'b0;
    if (!req_r.mode) begin
      if (req_r.req_size[31]) begin
        err_nxt = ssk_pkg::ERR_INVALID;
      end else if (req_r.key != ssk_pkg::PRIVATE_KEY && chain[SLOTS].found) begin
        if (req_r.create && req_r.exclusive) begin
          err_nxt = ssk_pkg::ERR_EXISTS;
        end else if (req_r.req_size[30:0] > chain[SLOTS].size) begin
          err_nxt = ssk_pkg::ERR_INVALID;
        end else begin
          ok_nxt = 1'b1;
          id_nxt = chain[SLOTS].match_id;
        end
      end else if (req_r.key != ssk_pkg::PRIVATE_KEY && !req_r.create) begin
        err_nxt = ssk_pkg::ERR_NOTFOUND;
      end else if (!chain[SLOTS].has_free) begin
        err_nxt = ssk_pkg::ERR_NOSPACE;
      end else begin
        ok_nxt   = 1'b1;
        id_nxt   = chain[SLOTS].free_id;
        do_alloc = pend_r;
      end
    end else begin
      if (req_r.ctl_op[31] || !tid_ok) begin
        err_nxt = ssk_pkg::ERR_INVALID;
      end else if (!used[tid_idx]) begin
        err_nxt = ssk_pkg::ERR_REMOVED;
      end else if (req_r.ctl_op != ssk_pkg::OP_REMOVE) begin
        err_nxt = ssk_pkg::ERR_INVALID;
      end else begin
        ok_nxt   = 1'b1;
        do_clear = pend_r;
      end
    end
  end

  assign pend_nxt = start && !pend_r;

  always_ff @(posedge clk) begin
    if (pend_nxt) req_r <= {in_mode, in_key, in_req_size, in_create, in_exclusive,
                            in_perm_bits, in_target_id, in_ctl_op};
    ok_r  <= ok_nxt;
    id_r  <= id_nxt;
    err_r <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      vld_r  <= pend_r;
    end
  end

  assign out_valid      = vld_r;
  assign out_ok         = ok_r;
  assign out_segment_id = id_r;
  assign out_error_code = err_r;
endmodule
`default_nettype wire
